// ===== design/csm_pkg.sv =====
// Shared types and constants for the CSR sparse matrix-vector multiplier.
// Holds the item structs, the opcodes and the default sizes; no dependencies.
package csm_pkg;

	// field widths
	localparam int OP_W    = 2;
	localparam int INDEX_W = 10;
	localparam int VALUE_W = 16;
	localparam int ROW_W   = 10;
	localparam int SUM_W   = 48;
	localparam int PROD_W  = 2 * VALUE_W;

	// vector store depth follows the index field
	localparam int VEC_DEPTH = 1 << INDEX_W;

	// default row counter wrap
	localparam int MAX_SIZE_DEF = 1024;

	typedef logic [OP_W-1:0] op_t;

	// opcodes; the fourth code is ignored
	localparam op_t OP_LOAD  = 2'd0;
	localparam op_t OP_NZ    = 2'd1;
	localparam op_t OP_EMPTY = 2'd2;

	typedef struct packed {
		op_t                       op;
		logic [INDEX_W-1:0]        index;
		logic signed [VALUE_W-1:0] value;
		logic                      row_end;
	} in_item_t;

	typedef struct packed {
		logic [ROW_W-1:0]        row;
		logic signed [SUM_W-1:0] sum;
	} out_item_t;

endpackage

// ===== design/csm_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Stand-alone; used for the dense vector store.
module csm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read port, data held until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== design/csr_sparse_matvec.sv =====
// CSR sparse matrix-vector multiplier, y = A*x in fixed point (Q8.8 in, Q32.16 out).
// Uses csm_pkg for item types and opcodes, and csm_ram for the vector store.
//
// Load x first with op 0 items (one element per item), then stream the matrix
// nonzeros row by row with op 1; the nonzero flagged row_end closes its row and
// emits the row number and the exact 48-bit sum, and an op 2 item emits a zero
// row. The block accepts one item every clock cycle while results are taken.
// Accepting the item that closes a row issues the vector store read; stage 2 then
// registers the 16x16 product, and the accumulate stage loads the sum into the
// output register. Input stall rises only when a row result reaches the
// accumulate stage while the previous result is still held by result_stall. The
// vector store has no reset: read only entries that have been loaded. The row
// counter wraps at MAX_SIZE and row carries its low 10 bits; op 3 items are
// dropped.
module csr_sparse_matvec #(
	parameter int MAX_SIZE = csm_pkg::MAX_SIZE_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  csm_pkg::in_item_t   item,
	output logic                result_valid,
	input  logic                result_stall,
	output csm_pkg::out_item_t  result
);
	import csm_pkg::*;

	localparam int CNT_W  = $clog2(MAX_SIZE);
	localparam int ROWX_W = (CNT_W > ROW_W) ? CNT_W : ROW_W;

	logic accept;
	logic adv;

	// vector store
	logic                we;
	logic                re;
	logic [VALUE_W-1:0]  rdata;

	// stage 1: read issued
	logic                      v_s1;
	logic                      empty_s1;
	logic                      last_s1;
	logic signed [VALUE_W-1:0] value_s1;

	// stage 2: product ready
	logic                      v_s2;
	logic                      empty_s2;
	logic                      last_s2;
	logic signed [PROD_W-1:0]  prod_s2;

	logic signed [PROD_W-1:0]  prod;
	logic [SUM_W-1:0]          acc_q;
	logic [SUM_W-1:0]          acc_sum;
	logic [CNT_W-1:0]          row_cnt_q;
	logic [ROWX_W-1:0]         row_ext;
	logic                      s2_emit;
	logic                      out_busy;

	// handshake and pipeline advance
	assign s2_emit    = v_s2 && (empty_s2 || last_s2);
	assign out_busy   = result_valid && result_stall;
	assign adv        = !(s2_emit && out_busy);
	assign item_stall = !adv;
	assign accept     = item_valid && adv;

	assign we = accept && (item.op == OP_LOAD);
	assign re = accept && (item.op == OP_NZ);

	csm_ram #(
		.WIDTH(VALUE_W),
		.DEPTH(VEC_DEPTH)
	) u_vec_ram (
		.clk   (clk),
		.we    (we),
		.waddr (item.index),
		.wdata (item.value),
		.re    (re),
		.raddr (item.index),
		.rdata (rdata)
	);

	// stage 1 control: only nonzero and empty-row items travel on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= accept && (item.op == OP_NZ || item.op == OP_EMPTY);
			v_s2 <= v_s1;
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		if (adv) begin
			empty_s1 <= (item.op == OP_EMPTY);
			last_s1  <= item.row_end;
			value_s1 <= item.value;
			empty_s2 <= empty_s1;
			last_s2  <= last_s1;
			prod_s2  <= prod;
		end
	end

	// multiply nonzero by vector element
	assign prod = value_s1 * $signed(rdata);

	// accumulate
	assign acc_sum = acc_q + {{(SUM_W-PROD_W){prod_s2[PROD_W-1]}}, prod_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q     <= '0;
			row_cnt_q <= '0;
		end else if (adv && v_s2) begin
			if (s2_emit) begin
				acc_q <= '0;
				if (row_cnt_q == CNT_W'(MAX_SIZE - 1)) begin
					row_cnt_q <= '0;
				end else begin
					row_cnt_q <= row_cnt_q + 1'b1;
				end
			end else begin
				acc_q <= acc_sum;
			end
		end
	end

	assign row_ext = ROWX_W'(row_cnt_q);

	// output register: load a result, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (adv && s2_emit) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && s2_emit) begin
			result.row <= row_ext[ROW_W-1:0];
			result.sum <= empty_s2 ? '0 : $signed(acc_sum);
		end
	end

`ifndef SYNTHESIS
	// input stalls only behind a held result
	assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (result_valid && result_stall))
		else $error("item stalled without a held result");

	// accumulator restarts after each emitted row
	assert property (@(posedge clk) disable iff (!arst_n)
		(adv && s2_emit) |=> (acc_q == '0))
		else $error("accumulator not cleared after row result");

	// emitted row brings a fresh valid result
	assert property (@(posedge clk) disable iff (!arst_n)
		(adv && s2_emit) |=> result_valid)
		else $error("row result not presented");

	// row counter stays below its wrap
	assert property (@(posedge clk) disable iff (!arst_n)
		row_cnt_q <= CNT_W'(MAX_SIZE - 1))
		else $error("row counter out of range");
`endif

endmodule
